[rtl/apop_pkg.sv]
package apop_pkg;

    localparam int unsigned MAX_STEPS_DEF  = 1024;
    localparam int unsigned COUNT_BITS_DEF = 24;

    localparam int unsigned PRICE_W = 32;
    localparam int unsigned SUM_W   = 42;
    localparam int unsigned TOTAL_W = 56;
    localparam int unsigned LEN_W   = 11;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned MUL_W   = 33;

    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [30:0] LN2_Q30   = 31'd744261118;
    localparam logic [31:0] ONE_Q31   = 32'h8000_0000;
    localparam int unsigned TAYLOR_N  = 10;

    localparam logic [IDX_W-1:0] REG_START    = 3'd0;
    localparam logic [IDX_W-1:0] REG_STRIKE   = 3'd1;
    localparam logic [IDX_W-1:0] REG_DRIFT    = 3'd2;
    localparam logic [IDX_W-1:0] REG_VOL      = 3'd3;
    localparam logic [IDX_W-1:0] REG_DISCOUNT = 3'd4;
    localparam logic [IDX_W-1:0] REG_PATH_LEN = 3'd5;

    typedef struct packed {
        logic [30:0] mult;
        logic [2:0]  shift;
    } t_recip;

    // exact v/n for v < 2^30: (v*mult) >> (30+shift)
    function automatic t_recip recip(input logic [3:0] n);
        t_recip r;
        r.mult  = 31'd1073741824;
        r.shift = 3'd0;
        case (n)
            4'd2:    begin r.mult = 31'd1073741824; r.shift = 3'd1; end
            4'd3:    begin r.mult = 31'd1431655766; r.shift = 3'd2; end
            4'd4:    begin r.mult = 31'd1073741824; r.shift = 3'd2; end
            4'd5:    begin r.mult = 31'd1717986919; r.shift = 3'd3; end
            4'd6:    begin r.mult = 31'd1431655766; r.shift = 3'd3; end
            4'd7:    begin r.mult = 31'd1227133514; r.shift = 3'd3; end
            4'd8:    begin r.mult = 31'd1073741824; r.shift = 3'd3; end
            4'd9:    begin r.mult = 31'd1908874354; r.shift = 3'd4; end
            4'd10:   begin r.mult = 31'd1717986919; r.shift = 3'd4; end
            default: begin r.mult = 31'd1073741824; r.shift = 3'd0; end
        endcase
        return r;
    endfunction

endpackage

[rtl/apop_mul.sv]
module apop_mul (
    input  logic                               i_clk,
    input  logic signed [apop_pkg::MUL_W-1:0]  i_a,
    input  logic signed [apop_pkg::MUL_W-1:0]  i_b,
    output logic signed [2*apop_pkg::MUL_W-1:0] o_prod
);

    logic signed [2*apop_pkg::MUL_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

[rtl/apop_div.sv]
module apop_div #(
    parameter int unsigned DW = apop_pkg::SUM_W,
    parameter int unsigned VW = apop_pkg::LEN_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);

    localparam int unsigned CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_div;
    logic [DW-1:0] r_quot;
    logic [VW:0]   n_trial;
    logic          n_ge;

    always_comb begin
        n_trial = {r_rem, r_quot[DW-1]};
        n_ge    = n_trial >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_quot <= i_dividend;
            end else if (r_busy) begin
                r_rem  <= n_ge ? VW'(n_trial - {1'b0, r_div}) : n_trial[VW-1:0];
                r_quot <= {r_quot[DW-2:0], n_ge};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a running divide");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy)
        else $error("divider did not start");

endmodule

[rtl/asian_option_path_payoff_core.sv]
// channel   | direction | valid        | ready        | payload
// sample in | input     | i_in_valid   | o_in_ready   | i_normal_sample
// result    | output    | o_out_valid  | i_out_ready  | o_path_payoff, o_payoff_total,
//           |           |              |              | o_paths_done, o_overflow_seen
// config    | input     | i_cfg_we     | none         | i_cfg_idx, i_cfg_data
// One shared 33x33 multiplier; a sample runs accept, exponent scaling, the ten Taylor terms
// (states TM, TD, TQ for each), then the price product, clamp and sum.
// A path end then runs a 42-step radix-2 divide by path_len, clamped to 2..MAX_STEPS.
// Reset is synchronous, active low, and loads the register defaults.
// A pending result holds in its register while the next sample is taken;
// a finished path waits only if that register is still full.
module asian_option_path_payoff_core #(
    parameter int unsigned MAX_STEPS  = apop_pkg::MAX_STEPS_DEF,
    parameter int unsigned COUNT_BITS = apop_pkg::COUNT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [15:0]                  i_normal_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [apop_pkg::PRICE_W-1:0]        o_path_payoff,
    output logic [apop_pkg::TOTAL_W-1:0]        o_payoff_total,
    output logic [COUNT_BITS-1:0]               o_paths_done,
    output logic                                o_overflow_seen,
    input  logic                                i_cfg_we,
    input  logic [apop_pkg::IDX_W-1:0]          i_cfg_idx,
    input  logic [apop_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int unsigned PW = apop_pkg::PRICE_W;
    localparam int unsigned SW = apop_pkg::SUM_W;
    localparam int unsigned TW = apop_pkg::TOTAL_W;
    localparam int unsigned LW = apop_pkg::LEN_W;
    localparam int unsigned MW = apop_pkg::MUL_W;

    typedef enum logic [4:0] {
        S_IDLE, S_VOL, S_X, S_YH, S_YL, S_Y, S_KF, S_T, S_T2, S_TM, S_TD, S_TQ,
        S_P, S_PS, S_SUM, S_DST, S_DIV, S_AVG, S_PM, S_PAY, S_EMIT
    } t_state;

    t_state r_state;

    logic [31:0]         r_start;
    logic [31:0]         r_strike;
    logic signed [31:0]  r_drift;
    logic [30:0]         r_vol;
    logic [31:0]         r_disc;
    logic [LW-1:0]       r_len_cfg;

    logic signed [15:0]  r_z;
    logic [PW-1:0]       r_price;
    logic [SW-1:0]       r_sum;
    logic [LW-1:0]       r_step;
    logic [TW-1:0]       r_total;
    logic [COUNT_BITS-1:0] r_count;
    logic                r_sticky;
    logic [34:0]         r_a;
    logic                r_neg;
    logic [35:0]         r_ya;
    logic signed [6:0]   r_k;
    logic [29:0]         r_f;
    logic [29:0]         r_t;
    logic [30:0]         r_term;
    logic [31:0]         r_e;
    logic [3:0]          r_n;
    logic [PW-1:0]       r_diff;
    logic [PW-1:0]       r_payoff;

    logic                r_out_valid;
    logic [PW-1:0]       r_out_payoff;
    logic [TW-1:0]       r_out_total;
    logic [COUNT_BITS-1:0] r_out_count;
    logic                r_out_ovf;

    logic signed [MW-1:0]   n_ma;
    logic signed [MW-1:0]   n_mb;
    logic signed [2*MW-1:0] w_prod;
    logic                   w_div_done;
    logic [SW-1:0]          w_quot;

    logic [LW-1:0]          n_len;
    logic signed [37:0]     n_x;
    logic signed [36:0]     n_y;
    apop_pkg::t_recip       n_rc;
    logic [30:0]            n_qterm;
    logic [62:0]            n_p;
    logic signed [7:0]      n_s;
    logic [2:0]             n_ls;
    logic [63:0]            n_r;
    logic [SW:0]            n_sum;
    logic [TW:0]            n_total;
    logic [31:0]            n_disc;

    localparam logic signed [37:0] X_LIMIT = 38'sd25769803776;

    apop_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (n_ma),
        .i_b    (n_mb),
        .o_prod (w_prod)
    );

    apop_div #(.DW(SW), .VW(LW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DST),
        .i_dividend (r_sum),
        .i_divisor  (n_len),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_comb begin
        n_len = r_len_cfg;
        if (r_len_cfg < LW'(2)) begin
            n_len = LW'(2);
        end else if (32'(r_len_cfg) > MAX_STEPS) begin
            n_len = LW'(MAX_STEPS);
        end

        n_x = 38'(r_drift) + 38'(w_prod >>> 12);
        if (n_x > X_LIMIT) begin
            n_x = X_LIMIT;
        end else if (n_x < -X_LIMIT) begin
            n_x = -X_LIMIT;
        end

        n_y = r_neg ? -$signed({1'b0, r_ya}) : $signed({1'b0, r_ya});

        n_rc    = apop_pkg::recip(r_n);
        n_qterm = 31'(w_prod[2*MW-1:0] >> (6'd30 + 6'(n_rc.shift)));

        n_p  = w_prod[62:0];
        n_s  = 8'sd30 - 8'(r_k);
        n_ls = 3'(-n_s);
        n_r  = '0;
        if (n_s >= 8'sd64) begin
            n_r = '0;
        end else if (n_s >= 8'sd0) begin
            n_r = {1'b0, n_p} >> n_s[5:0];
        end else if (n_p > (63'(32'hFFFF_FFFF) >> n_ls)) begin
            n_r = 64'h1_0000_0000;
        end else begin
            n_r = {1'b0, n_p} << n_ls;
        end

        n_sum   = {1'b0, r_sum} + (SW+1)'(r_price);
        n_total = {1'b0, r_total} + (TW+1)'(w_prod[62:31]);
        n_disc  = (r_disc > apop_pkg::ONE_Q31) ? apop_pkg::ONE_Q31 : r_disc;

        n_ma = '0;
        n_mb = '0;
        case (r_state)
            S_VOL: begin n_ma = MW'(r_vol);          n_mb = MW'(r_z); end
            S_YH:  begin n_ma = MW'(r_a[34:30]);     n_mb = MW'(apop_pkg::LOG2E_Q30); end
            S_YL:  begin n_ma = MW'(r_a[29:0]);      n_mb = MW'(apop_pkg::LOG2E_Q30); end
            S_T:   begin n_ma = MW'(r_f);            n_mb = MW'(apop_pkg::LN2_Q30); end
            S_TM:  begin n_ma = MW'(r_term);         n_mb = MW'(r_t); end
            S_TD:  begin n_ma = MW'(w_prod[59:30]);  n_mb = MW'(n_rc.mult); end
            S_P:   begin n_ma = MW'(r_price);        n_mb = MW'(r_e); end
            S_PM:  begin n_ma = MW'(r_diff);         n_mb = MW'(n_disc); end
            default: begin n_ma = '0; n_mb = '0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 32'd6553600;
            r_strike    <= 32'd6553600;
            r_drift     <= '0;
            r_vol       <= '0;
            r_disc      <= apop_pkg::ONE_Q31;
            r_len_cfg   <= LW'(30);
            r_price     <= 32'd6553600;
            r_sum       <= SW'(6553600);
            r_step      <= '0;
            r_total     <= '0;
            r_count     <= '0;
            r_sticky    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    apop_pkg::REG_START:    r_start   <= i_cfg_data;
                    apop_pkg::REG_STRIKE:   r_strike  <= i_cfg_data;
                    apop_pkg::REG_DRIFT:    r_drift   <= i_cfg_data;
                    apop_pkg::REG_VOL:      r_vol     <= i_cfg_data[30:0];
                    apop_pkg::REG_DISCOUNT: r_disc    <= i_cfg_data;
                    apop_pkg::REG_PATH_LEN: r_len_cfg <= i_cfg_data[LW-1:0];
                    default: ;
                endcase
            end

            if (r_out_valid && i_out_ready && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_z <= i_normal_sample;
                        if (r_step == '0) begin
                            r_price <= r_start;
                            r_sum   <= SW'(r_start);
                        end
                        r_state <= S_VOL;
                    end
                end
                S_VOL: r_state <= S_X;
                S_X: begin
                    r_neg   <= n_x < 0;
                    r_a     <= 35'(n_x < 0 ? -n_x : n_x);
                    r_state <= S_YH;
                end
                S_YH: r_state <= S_YL;
                S_YL: begin
                    r_ya    <= 36'(w_prod);
                    r_state <= S_Y;
                end
                S_Y: begin
                    r_ya    <= r_ya + 36'(w_prod >>> 30);
                    r_state <= S_KF;
                end
                S_KF: begin
                    r_k     <= n_y[36:30];
                    r_f     <= n_y[29:0];
                    r_state <= S_T;
                end
                S_T: r_state <= S_T2;
                S_T2: begin
                    r_t     <= w_prod[59:30];
                    r_term  <= 31'h4000_0000;
                    r_e     <= 32'h4000_0000;
                    r_n     <= 4'd1;
                    r_state <= S_TM;
                end
                S_TM: r_state <= S_TD;
                S_TD: r_state <= S_TQ;
                S_TQ: begin
                    r_term <= n_qterm;
                    r_e    <= r_e + 32'(n_qterm);
                    if (r_n == 4'(apop_pkg::TAYLOR_N)) begin
                        r_state <= S_P;
                    end else begin
                        r_n     <= r_n + 4'd1;
                        r_state <= S_TM;
                    end
                end
                S_P: r_state <= S_PS;
                S_PS: begin
                    if (n_r > 64'hFFFF_FFFF) begin
                        r_price  <= '1;
                        r_sticky <= 1'b1;
                    end else begin
                        r_price <= n_r[PW-1:0];
                    end
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    if (n_sum[SW]) begin
                        r_sum    <= '1;
                        r_sticky <= 1'b1;
                    end else begin
                        r_sum <= n_sum[SW-1:0];
                    end
                    if (r_step + 1'b1 >= n_len - 1'b1) begin
                        r_step  <= '0;
                        r_state <= S_DST;
                    end else begin
                        r_step  <= r_step + 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_DST: r_state <= S_DIV;
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_AVG;
                    end
                end
                S_AVG: begin
                    if (w_quot > SW'(32'hFFFF_FFFF)) begin
                        r_diff <= ('1 > r_strike) ? '1 - r_strike : '0;
                    end else begin
                        r_diff <= (w_quot[PW-1:0] > r_strike) ? w_quot[PW-1:0] - r_strike : '0;
                    end
                    r_state <= S_PM;
                end
                S_PM: r_state <= S_PAY;
                S_PAY: begin
                    r_payoff <= w_prod[62:31];
                    if (n_total[TW]) begin
                        r_total  <= '1;
                        r_sticky <= 1'b1;
                    end else begin
                        r_total <= n_total[TW-1:0];
                    end
                    if (r_count != '1) begin
                        r_count <= r_count + 1'b1;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_payoff <= r_payoff;
                        r_out_total  <= r_total;
                        r_out_count  <= r_count;
                        r_out_ovf    <= r_sticky;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready      = r_state == S_IDLE;
    assign o_out_valid     = r_out_valid;
    assign o_path_payoff   = r_out_payoff;
    assign o_payoff_total  = r_out_total;
    assign o_paths_done    = r_out_count;
    assign o_overflow_seen = r_out_ovf;

    a_count_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 r_count >= $past(r_count))
        else $error("path count went down");

    a_sticky_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sticky |=> r_sticky)
        else $error("overflow flag cleared");

    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EMIT))
        else $error("result raised outside emit");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_state == S_VOL)
        else $error("accepted item not started");

endmodule
